/* hw/rtl/pcfd_pkg.sv */
// Shared types and constants for the filtered-derivative PID unit.
// No dependencies; compile first.
`default_nettype none

package pcfd_pkg;

  localparam int SAMPLE_W  = 16;  // target / measured sample width
  localparam int ERR_W     = 17;  // error = target - measured
  localparam int ERR2_W    = 18;  // error sum / difference
  localparam int COEF_W    = 32;  // Q16.16 gains and offset
  localparam int STATE_W   = 48;  // Q32.16 stored terms
  localparam int DRIVE_W   = 32;  // integer drive value
  localparam int FRAC_W    = 16;  // fraction bits of Q16.16
  localparam int CFG_IDX_W = 3;

  // Request opcodes
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_POL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd4;

  // Classified request handed from front to back
  typedef struct packed {
    logic                     op;
    logic signed [ERR_W-1:0]  err;
    logic signed [ERR2_W-1:0] err_sum;
    logic signed [ERR2_W-1:0] err_diff;
  } pcfd_cmd_t;

  // Configuration register bank
  typedef struct packed {
    logic signed [COEF_W-1:0] kp;
    logic signed [COEF_W-1:0] ki;
    logic signed [COEF_W-1:0] kd;
    logic signed [COEF_W-1:0] pole;
    logic signed [COEF_W-1:0] offset;
  } pcfd_gains_t;

endpackage

`default_nettype wire

/* hw/rtl/pcfd_ifs.sv */
// Valid/ready channel interfaces: sample input, drive output, config write.
// Depends on pcfd_pkg.
`default_nettype none

interface pcfd_in_if;
  import pcfd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic signed [SAMPLE_W-1:0] target_value;
  logic signed [SAMPLE_W-1:0] measured_value;
  modport source (output valid, op, target_value, measured_value, input ready);
  modport sink   (input valid, op, target_value, measured_value, output ready);
endinterface

interface pcfd_out_if;
  import pcfd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_value;
  logic                      saturated;
  modport source (output valid, drive_value, saturated, input ready);
  modport sink   (input valid, drive_value, saturated, output ready);
endinterface

interface pcfd_cfg_if;
  import pcfd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pcfd_front.sv */
// Front end: accept sample requests, form error, error sum and difference.
// Depends on pcfd_pkg and pcfd_ifs.
`default_nettype none

module pcfd_front (
  input  wire                  clk,
  input  wire                  rst_n,
  pcfd_in_if.sink              in_ch,
  output logic                 push_valid,
  input  wire                  push_ready,
  output pcfd_pkg::pcfd_cmd_t  push_data
);
  import pcfd_pkg::*;

  logic signed [ERR_W-1:0] last_err_r, last_err_nxt;
  logic signed [ERR_W-1:0] err;
  logic                    accept;

  assign err = ERR_W'(in_ch.target_value) - ERR_W'(in_ch.measured_value);

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign accept      = in_ch.valid && push_ready;

  always_comb begin
    push_data.op       = in_ch.op;
    push_data.err      = err;
    push_data.err_sum  = ERR2_W'(err) + ERR2_W'(last_err_r);
    push_data.err_diff = ERR2_W'(err) - ERR2_W'(last_err_r);
  end

  // Track previous error; a clear drops it to zero
  always_comb begin
    last_err_nxt = last_err_r;
    if (accept) begin
      last_err_nxt = (in_ch.op == OP_CLEAR) ? '0 : err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
    end else begin
      last_err_r <= last_err_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pcfd_queue.sv */
// Small FIFO of classified requests between front and back.
// Depends on pcfd_pkg.
`default_nettype none

module pcfd_queue #(
  parameter int DEPTH = 2
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push_valid,
  output logic                 push_ready,
  input  pcfd_pkg::pcfd_cmd_t  push_data,
  output logic                 pop_valid,
  input  wire                  pop_ready,
  output pcfd_pkg::pcfd_cmd_t  pop_data
);
  import pcfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pcfd_cmd_t         slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pcfd_back.sv */
// Back end: sequence one shared multiplier through the PID products, hold
// integral and derivative state, saturate and drive the output register.
// Depends on pcfd_pkg and pcfd_ifs.
`default_nettype none

module pcfd_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  pcfd_pkg::pcfd_gains_t gains,
  input  wire                  pop_valid,
  output logic                 pop_ready,
  input  pcfd_pkg::pcfd_cmd_t  pop_data,
  pcfd_out_if.source           out_ch
);
  import pcfd_pkg::*;

  localparam int MUL_B_W = COEF_W + 1;
  localparam int PROD_W  = COEF_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int RND_W   = PROD_W - FRAC_W;
  localparam int TOT_W   = STATE_W + 4;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_LO   = 8'b0000_0010,
    ST_HI   = 8'b0000_0100,
    ST_KD   = 8'b0000_1000,
    ST_KI   = 8'b0001_0000,
    ST_KP   = 8'b0010_0000,
    ST_SUM  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } pcfd_state_t;

  typedef struct packed {
    logic signed [STATE_W-1:0] val;
    logic                      hit;
  } pcfd_clamp_t;

  function automatic pcfd_clamp_t clamp_state(input logic signed [ACC_W-1:0] v);
    pcfd_clamp_t res;
    res.val = v[STATE_W-1:0];
    res.hit = 1'b0;
    if (!v[ACC_W-1] && (|v[ACC_W-2:STATE_W-1])) begin
      res.val = {1'b0, {(STATE_W-1){1'b1}}};
      res.hit = 1'b1;
    end else if (v[ACC_W-1] && !(&v[ACC_W-2:STATE_W-1])) begin
      res.val = {1'b1, {(STATE_W-1){1'b0}}};
      res.hit = 1'b1;
    end
    return res;
  endfunction

  pcfd_state_t state_r, state_nxt;

  pcfd_cmd_t                 cmd_r;
  logic signed [STATE_W-1:0] integ_r;
  logic signed [STATE_W-1:0] deriv_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [TOT_W-1:0]   total_r;
  logic                      sat_r;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [DRIVE_W-1:0] drive_r;
  logic                      sat_out_r;

  logic signed [COEF_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_c;
  logic signed [PROD_W-1:0]  rnd_sum;
  logic signed [RND_W-1:0]   rnd_q;
  logic signed [ACC_W-1:0]   integ_sum;
  pcfd_clamp_t               integ_cl;
  pcfd_clamp_t               deriv_cl;
  logic signed [DRIVE_W-1:0] drive_c;
  logic                      drive_hit;
  logic                      load_out;

  // Shared multiplier operand select
  always_comb begin
    mul_a = gains.kp;
    mul_b = MUL_B_W'(cmd_r.err);
    case (state_r)
      ST_LO: begin
        mul_a = gains.pole;
        mul_b = {{(MUL_B_W-FRAC_W){1'b0}}, deriv_r[FRAC_W-1:0]};
      end
      ST_HI: begin
        mul_a = gains.pole;
        mul_b = {{(MUL_B_W-(STATE_W-FRAC_W)){deriv_r[STATE_W-1]}},
                 deriv_r[STATE_W-1:FRAC_W]};
      end
      ST_KD: begin
        mul_a = gains.kd;
        mul_b = MUL_B_W'(cmd_r.err_diff);
      end
      ST_KI: begin
        mul_a = gains.ki;
        mul_b = MUL_B_W'(cmd_r.err_sum);
      end
      default: begin
        mul_a = gains.kp;
        mul_b = MUL_B_W'(cmd_r.err);
      end
    endcase
  end

  assign prod_c = mul_a * mul_b;

  // Round pole * low part to Q.16, ties toward +inf
  assign rnd_sum   = prod_r + PROD_W'(1 << (FRAC_W - 1));
  assign rnd_q     = rnd_sum[PROD_W-1:FRAC_W];
  assign integ_sum = ACC_W'(integ_r) + ACC_W'(prod_r);
  assign integ_cl  = clamp_state(integ_sum);
  assign deriv_cl  = clamp_state(acc_r);

  // Floor to integer, saturate to drive range
  always_comb begin
    drive_c   = total_r[FRAC_W+DRIVE_W-1:FRAC_W];
    drive_hit = 1'b0;
    if (!total_r[TOT_W-1] && (|total_r[TOT_W-2:FRAC_W+DRIVE_W-1])) begin
      drive_c   = {1'b0, {(DRIVE_W-1){1'b1}}};
      drive_hit = 1'b1;
    end else if (total_r[TOT_W-1] && !(&total_r[TOT_W-2:FRAC_W+DRIVE_W-1])) begin
      drive_c   = {1'b1, {(DRIVE_W-1){1'b0}}};
      drive_hit = 1'b1;
    end
  end

  assign pop_ready = (state_r == ST_IDLE);
  assign load_out  = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid && pop_data.op == OP_STEP) begin
          state_nxt = ST_LO;
        end
      end
      ST_LO:  state_nxt = ST_HI;
      ST_HI:  state_nxt = ST_KD;
      ST_KD:  state_nxt = ST_KI;
      ST_KI:  state_nxt = ST_KP;
      ST_KP:  state_nxt = ST_SUM;
      ST_SUM: state_nxt = ST_OUT;
      ST_OUT: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      deriv_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      // Clear request: zero stored terms
      if (state_r == ST_IDLE && pop_valid && pop_data.op == OP_CLEAR) begin
        integ_r <= '0;
        deriv_r <= '0;
      end
      if (state_r == ST_KP) begin
        integ_r <= integ_cl.val;
        deriv_r <= deriv_cl.val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && pop_valid) begin
      cmd_r <= pop_data;
    end
    prod_r <= prod_c;
    case (state_r)
      ST_HI:   acc_r <= ACC_W'(rnd_q);
      ST_KD:   acc_r <= acc_r + ACC_W'(prod_r);
      ST_KI:   acc_r <= acc_r + ACC_W'(prod_r);
      default: acc_r <= acc_r;
    endcase
    if (state_r == ST_KP) begin
      sat_r <= integ_cl.hit | deriv_cl.hit;
    end
    if (state_r == ST_SUM) begin
      total_r <= TOT_W'(prod_r) + TOT_W'(integ_r) + TOT_W'(deriv_r)
               + TOT_W'(gains.offset);
    end
    if (load_out) begin
      drive_r   <= drive_c;
      sat_out_r <= sat_r | drive_hit;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive_value = drive_r;
  assign out_ch.saturated   = sat_out_r;

endmodule

`default_nettype wire

/* hw/rtl/pid_controller_filtered_derivative_unit.sv */
// Top level of the filtered-derivative PID unit: config bank, front end,
// request queue and back end. Depends on pcfd_pkg, pcfd_ifs and submodules.
`default_nettype none

// Discrete PID controller with trapezoidal integral and filtered derivative.
// Each step request carries a target and a measured sample; the unit forms
// error = target - measured and returns one drive value equal to
//   kp*e + I + D + offset, floored to an integer and saturated to 32 bits,
// where I += ki*(e + e_prev) and D = kd*(e - e_prev) + round(pole*D_prev),
// both held as Q32.16 and saturated to 48 bits. The saturated flag reports
// any clamp on that step. A clear request zeroes I, D and the previous error
// and returns nothing. Gains and offset are Q16.16 registers at config
// indexes 0..4 (kp, ki, kd, pole, offset); indexes 5..7 are ignored. Write
// config only while the unit is idle; the config channel is always ready.
// Timing: the front end takes a request in any cycle the queue has room, so
// with the back end idle a burst of QUEUE_DEPTH + 1 requests goes in back to
// back. The back end runs one shared 32x33 multiplier through five products
// per step, then a sum state and an output-load state, and takes no new
// request until the step is through; a clear request is retired in the idle
// state. The output load waits while an earlier result is still unaccepted.
// A finished result waits in the output register while the back end starts
// on the next request.
module pid_controller_filtered_derivative_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire         clk,
  input  wire         rst_n,
  pcfd_cfg_if.sink    cfg_ch,
  pcfd_in_if.sink     in_ch,
  pcfd_out_if.source  out_ch
);
  import pcfd_pkg::*;

  pcfd_gains_t gains_r, gains_nxt;

  logic      push_valid, push_ready;
  pcfd_cmd_t push_data;
  logic      pop_valid, pop_ready;
  pcfd_cmd_t pop_data;

  // Config writes never stall
  assign cfg_ch.ready = 1'b1;

  // Decode the write index; drop writes to unused indexes
  always_comb begin
    gains_nxt = gains_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_GAIN_P:    gains_nxt.kp     = cfg_ch.data;
        REG_GAIN_I:    gains_nxt.ki     = cfg_ch.data;
        REG_GAIN_D:    gains_nxt.kd     = cfg_ch.data;
        REG_DERIV_POL: gains_nxt.pole   = cfg_ch.data;
        REG_OFFSET:    gains_nxt.offset = cfg_ch.data;
        default:       gains_nxt        = gains_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
    end else begin
      gains_r <= gains_nxt;
    end
  end

  // Front end: classify requests and compute error terms
  pcfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouple front from back
  pcfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: products, state update, saturation and output register
  pcfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .gains     (gains_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for pid_controller_filtered_derivative_unit.
// Drives step and clear requests plus gain writes, predicts each drive value in
// a bit-accurate PID model. Depends on pcfd_pkg, pcfd_ifs and the unit's RTL.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcfd_pkg::*;

  // Run shape
  localparam int PHASES          = 13;
  localparam int REQS_PER_PHASE  = 100;
  localparam int SETTLE_CYCLES   = 24;      // a clear may still be in flight
  localparam int HOLD_AT         = 450;     // request count that starts the long hold-off
  localparam int HOLD_CYCLES     = 300;
  localparam int CYCLE_LIMIT     = 600_000;
  localparam int RESET_CYCLES    = 6;

  // Highest config index; 5..7 are unmapped and must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_IDX_TOP = '1;

  // Model arithmetic is done at 96 bits so no intermediate can wrap
  typedef logic signed [95:0] acc_t;
  localparam acc_t STATE_HI   = 96'sh7FFF_FFFF_FFFF;
  localparam acc_t STATE_LO   = -STATE_HI - 96'sd1;
  localparam acc_t OUT_HI     = 96'sh7FFF_FFFF;
  localparam acc_t OUT_LO     = -OUT_HI - 96'sd1;
  localparam acc_t ROUND_HALF = 96'sd32768;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      sat;
  } drive_result_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_STEP, ROW_CLEAR} row_kind_t;

  // One line of stimulus: a gain write, a step or a clear. A step may carry
  // a typed-in expectation that replaces the model's answer.
  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [COEF_W-1:0]          data;
    logic signed [SAMPLE_W-1:0] tgt;
    logic signed [SAMPLE_W-1:0] meas;
    logic                       typed;
    logic signed [DRIVE_W-1:0]  exp_drive;
    logic                       exp_sat;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  pcfd_cfg_if cfg_bus ();
  pcfd_in_if  in_bus ();
  pcfd_out_if out_bus ();

  pid_controller_filtered_derivative_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_bus),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #1 clk = ~clk;

  // Controller model: gains, offset and loop state
  logic signed [COEF_W-1:0]  kp_q, ki_q, kd_q, pole_q, off_q;
  logic signed [STATE_W-1:0] integ_q, deriv_q;
  logic signed [ERR_W-1:0]   prev_err_q;

  drive_result_t pending_drives[$];   // drive values owed by the unit, oldest first
  plan_row_t     directed_plan[$];
  int            requests_issued = 0;
  int            mismatch_count = 0;
  bit            steady_phase = 1'b0; // no idling on either side while set
  logic          hold_off;

  function automatic acc_t saturate(input acc_t v, input acc_t lo, input acc_t hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void set_gain(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [COEF_W-1:0] value);
    case (idx)
      REG_GAIN_P:    kp_q = value;
      REG_GAIN_I:    ki_q = value;
      REG_GAIN_D:    kd_q = value;
      REG_DERIV_POL: pole_q = value;
      REG_OFFSET:    off_q = value;
      default: ;
    endcase
  endfunction

  function automatic void clear_loop_state();
    integ_q = '0;
    deriv_q = '0;
    prev_err_q = '0;
  endfunction

  // Advance the model by one control step and return the drive it produces.
  function automatic drive_result_t next_drive(input logic signed [SAMPLE_W-1:0] tgt,
                                               input logic signed [SAMPLE_W-1:0] meas);
    acc_t err, err_prev, prop, raw, integ, deriv, drive;
    drive_result_t res;
    err = acc_t'(tgt) - acc_t'(meas);
    err_prev = acc_t'(prev_err_q);
    prop = acc_t'(kp_q) * err;
    // trapezoidal integral, clamped to the 48-bit state range
    raw = acc_t'(integ_q) + acc_t'(ki_q) * (err + err_prev);
    integ = saturate(raw, STATE_LO, STATE_HI);
    res.sat = (integ != raw);
    // filtered derivative; the pole product rounds half toward +infinity
    raw = acc_t'(kd_q) * (err - err_prev)
        + ((acc_t'(pole_q) * acc_t'(deriv_q) + ROUND_HALF) >>> FRAC_W);
    deriv = saturate(raw, STATE_LO, STATE_HI);
    res.sat = res.sat | (deriv != raw);
    raw = (prop + integ + deriv + acc_t'(off_q)) >>> FRAC_W;
    drive = saturate(raw, OUT_LO, OUT_HI);
    res.sat = res.sat | (drive != raw);
    res.drive = drive[DRIVE_W-1:0];
    integ_q = integ[STATE_W-1:0];
    deriv_q = deriv[STATE_W-1:0];
    prev_err_q = err[ERR_W-1:0];
    return res;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [COEF_W-1:0] value);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = value;
    return r;
  endfunction

  function automatic plan_row_t step_row(input logic signed [SAMPLE_W-1:0] tgt,
                                         input logic signed [SAMPLE_W-1:0] meas);
    plan_row_t r;
    r = '0;
    r.kind = ROW_STEP;
    r.tgt = tgt;
    r.meas = meas;
    return r;
  endfunction

  function automatic plan_row_t check_row(input logic signed [SAMPLE_W-1:0] tgt,
                                          input logic signed [SAMPLE_W-1:0] meas,
                                          input logic signed [DRIVE_W-1:0] drive,
                                          input logic sat);
    plan_row_t r;
    r = step_row(tgt, meas);
    r.typed = 1'b1;
    r.exp_drive = drive;
    r.exp_sat = sat;
    return r;
  endfunction

  function automatic plan_row_t clear_row();
    plan_row_t r;
    r = '0;
    r.kind = ROW_CLEAR;
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int unsigned r;
    if (steady_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Gains: mostly moderate so outputs stay readable, some full-range, some corners.
  // The pole is kept below 1.0 in the moderate case so the derivative settles.
  function automatic logic [COEF_W-1:0] pick_coef(input logic [CFG_IDX_W-1:0] idx,
                                                  input bit wild);
    int unsigned r;
    logic [COEF_W-1:0] mag;
    r = $urandom_range(0, 99);
    if (wild || r < 12) begin
      case ($urandom_range(0, 4))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return '0;
        3: return 32'h0000_0001;
        default: return '1;
      endcase
    end
    if (r < 30) return $urandom();
    mag = (idx == REG_DERIV_POL) ? $urandom_range(0, 32'h0000_F000)
                                 : $urandom_range(0, 32'h0004_0000);
    return ($urandom_range(0, 1) != 0) ? -mag : mag;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return SAMPLE_W'($urandom());
    if (r < 85) return SAMPLE_W'($urandom_range(0, 600)) - 16'sd300;
    case ($urandom_range(0, 3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic plan_row_t random_request();
    logic signed [SAMPLE_W-1:0] tgt;
    if ($urandom_range(0, 99) < 8) return clear_row();
    tgt = pick_sample();
    // zero error now and then, so the loop sees a settled input
    return step_row(tgt, ($urandom_range(0, 9) == 0) ? tgt : pick_sample());
  endfunction

  // Wait until the unit owes nothing and any trailing clear has retired.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    drain();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    set_gain(idx, value);
  endtask

  // Offer one request, hold it until accepted, then book its expected drive.
  // Valid is only lowered ahead of a gap, never in the step that raises it again.
  task automatic push_request(input plan_row_t row);
    int gap;
    drive_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.op             <= (row.kind == ROW_CLEAR) ? OP_CLEAR : OP_STEP;
    in_bus.target_value   <= row.tgt;
    in_bus.measured_value <= row.meas;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    requests_issued++;
    if (row.kind == ROW_CLEAR) begin
      clear_loop_state();
    end else begin
      res = next_drive(row.tgt, row.meas);
      if (row.typed) res = '{row.exp_drive, row.exp_sat};
      pending_drives.push_back(res);
    end
  endtask

  task automatic issue_row(input plan_row_t row);
    if (row.kind == ROW_CFG) begin
      write_reg(row.idx, row.data);
    end else begin
      push_request(row);
    end
  endtask

  // Result side: check every accepted drive against the oldest expectation,
  // then pick ready for the next edge (random stalls, plus the long hold-off).
  initial begin : result_monitor
    int stall;
    drive_result_t want;
    out_bus.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) begin
        if (pending_drives.size() == 0) begin
          $display("%0t unexpected result: drive %0d sat %0b", $time,
                   out_bus.drive_value, out_bus.saturated);
          mismatch_count++;
        end else begin
          want = pending_drives.pop_front();
          if (out_bus.drive_value !== want.drive) begin
            $display("%0t drive_value mismatch: expected %0d, got %0d", $time,
                     want.drive, out_bus.drive_value);
            mismatch_count++;
          end
          if (out_bus.saturated !== want.sat) begin
            $display("%0t saturated mismatch: expected %0b, got %0b", $time,
                     want.sat, out_bus.saturated);
            mismatch_count++;
          end
        end
      end
      if (!rst_n || hold_off) begin
        out_bus.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_bus.ready <= 1'b0;
      end else begin
        stall = pick_gap();
        out_bus.ready <= (stall == 0);
      end
    end
  end

  // Hold the result side off for a long stretch once the run is well underway,
  // while requests keep coming, so the request queue fills and in_ch stalls.
  initial begin : long_hold
    hold_off = 1'b0;
    wait (requests_issued >= HOLD_AT);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog: end the run if it drags far past the slowest correct pace
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_IDX_W-1:0] gain_regs[5];
    bit wild;
    gain_regs = '{REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_DERIV_POL, REG_OFFSET};

    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.op = OP_STEP;
    in_bus.target_value = '0;
    in_bus.measured_value = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_GAIN_P;
    cfg_bus.data = '0;
    kp_q = '0;
    ki_q = '0;
    kd_q = '0;
    pole_q = '0;
    off_q = '0;
    clear_loop_state();

    // Directed part. Typed expectations only where the answer is obvious:
    // zero gains after reset, unity proportional gain, offset corners and
    // the saturating corner with maximum proportional and integral gains.
    directed_plan = '{
      check_row(16'sd0, 16'sd0, 32'sd0, 1'b0),
      check_row(16'sh7FFF, 16'sh8000, 32'sd0, 1'b0),
      clear_row(),
      cfg_row(REG_GAIN_P, 32'h0001_0000),
      check_row(16'sh7FFF, 16'sh8000, 32'sd65535, 1'b0),
      check_row(16'sh8000, 16'sh7FFF, -32'sd65535, 1'b0),
      cfg_row(REG_GAIN_P, 32'h0000_0000),
      cfg_row(REG_OFFSET, 32'h7FFF_FFFF),
      check_row(16'sd5, 16'sd5, 32'sd32767, 1'b0),
      cfg_row(REG_OFFSET, 32'h8000_0000),
      check_row(-16'sd1, -16'sd1, -32'sd32768, 1'b0),
      // half-LSB offset and a tiny derivative with pole 0.5: rounding ties
      cfg_row(REG_OFFSET, 32'h0000_8000),
      cfg_row(REG_GAIN_I, 32'h0001_0000),
      cfg_row(REG_GAIN_D, 32'h0000_0001),
      cfg_row(REG_DERIV_POL, 32'h0000_8000),
      step_row(16'sd100, 16'sd0),
      step_row(-16'sd7, 16'sd3),
      step_row(16'sd1, 16'sd0),
      cfg_row(REG_DERIV_POL, 32'h8000_0000),
      step_row(16'sh8000, 16'sh7FFF),
      step_row(16'sh7FFF, 16'sh8000),
      clear_row(),
      cfg_row(REG_GAIN_P, 32'h7FFF_FFFF),
      cfg_row(REG_GAIN_I, 32'h7FFF_FFFF),
      cfg_row(REG_GAIN_D, 32'h0000_0000),
      cfg_row(REG_DERIV_POL, 32'h0000_0000),
      cfg_row(REG_OFFSET, 32'h0000_0000),
      check_row(16'sh7FFF, 16'sh8000, 32'sh7FFF_FFFF, 1'b1),
      clear_row(),
      check_row(16'sh8000, 16'sh7FFF, 32'sh8000_0000, 1'b1),
      step_row(16'sh8000, 16'sh7FFF),   // integral now clamps at the 48-bit floor
      cfg_row(REG_IDX_TOP, 32'hFFFF_FFFF),
      step_row(16'sd12, -16'sd3)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i]) issue_row(directed_plan[i]);

    // Random part: each phase reloads every gain, sometimes all at corner values,
    // sometimes pokes an unmapped index, then streams requests.
    for (int phase = 0; phase < PHASES; phase++) begin
      wild = (phase % 5 == 3);
      foreach (gain_regs[k]) issue_row(cfg_row(gain_regs[k], pick_coef(gain_regs[k], wild)));
      if ($urandom_range(0, 2) == 0)
        issue_row(cfg_row(CFG_IDX_W'($urandom_range(REG_OFFSET + 1, REG_IDX_TOP)), $urandom()));
      steady_phase = (phase % 4 == 2);
      for (int n = 0; n < REQS_PER_PHASE; n++) issue_row(random_request());
      steady_phase = 1'b0;
    end

    // Drop valid, collect what is still owed, then allow a last settle.
    drain();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/pcfd_pkg.sv
hw/rtl/pcfd_ifs.sv
hw/rtl/pcfd_front.sv
hw/rtl/pcfd_queue.sv
hw/rtl/pcfd_back.sv
hw/rtl/pid_controller_filtered_derivative_unit.sv
tb/testbench.sv
